@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh: shared assertion shorthands
// The enclosing module must have clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");

`endif

@@ rtl/g128a_pkg.sv @@
// ----------------------------------------------------------------------------
// g128a_pkg: Grain-128AEAD byte-step constants and feedback functions
// Eight-way parallel forms of the pre-output, LFSR and NFSR feedback.
// ----------------------------------------------------------------------------
package g128a_pkg;

	localparam int StateW = 128;
	localparam int HalfW  = 64;
	localparam int StepW  = 8;

	typedef logic [StateW-1:0] state_t;
	typedef logic [HalfW-1:0]  half_t;
	typedef logic [StepW-1:0]  byte_t;

	// Input word kinds
	localparam logic KindStep = 1'b0;
	localparam logic KindLoad = 1'b1;

	// Pre-output bits for steps t..t+7; all taps stay below the fed-back bits
	function automatic byte_t pre_byte(input state_t s, input state_t b);
		byte_t y;
		for (int j = 0; j < StepW; j++) begin
			y[j] = (b[12+j] & s[8+j]) ^ (s[13+j] & s[20+j])
				^ (b[95+j] & s[42+j]) ^ (s[60+j] & s[79+j])
				^ (b[12+j] & b[95+j] & s[94+j])
				^ s[93+j] ^ b[2+j] ^ b[15+j] ^ b[36+j] ^ b[45+j]
				^ b[64+j] ^ b[73+j] ^ b[89+j];
		end
		return y;
	endfunction

	// LFSR feedback bits f for steps t..t+7
	function automatic byte_t lfsr_fb(input state_t s);
		byte_t f;
		for (int j = 0; j < StepW; j++) begin
			f[j] = s[j] ^ s[7+j] ^ s[38+j] ^ s[70+j] ^ s[81+j] ^ s[96+j];
		end
		return f;
	endfunction

	// NFSR feedback bits g ^ s0 for steps t..t+7
	function automatic byte_t nfsr_fb(input state_t s, input state_t b);
		byte_t g;
		for (int j = 0; j < StepW; j++) begin
			g[j] = b[j] ^ b[26+j] ^ b[56+j] ^ b[91+j] ^ b[96+j]
				^ (b[3+j] & b[67+j]) ^ (b[11+j] & b[13+j])
				^ (b[17+j] & b[18+j]) ^ (b[27+j] & b[59+j])
				^ (b[40+j] & b[48+j]) ^ (b[61+j] & b[65+j])
				^ (b[68+j] & b[84+j])
				^ (b[22+j] & b[24+j] & b[25+j])
				^ (b[70+j] & b[78+j] & b[82+j])
				^ (b[88+j] & b[92+j] & b[93+j] & b[95+j])
				^ s[j];
		end
		return g;
	endfunction

endpackage

@@ rtl/grain128aead_byte_step.sv @@
// ----------------------------------------------------------------------------
// grain128aead_byte_step: Grain-128AEAD pre-output generator, 8 steps per word
// Holds the 128-bit LFSR and NFSR and emits one pre-output byte per step word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word: kind selects a step
//   (emit a byte, advance both registers by eight) or a load (write a 64-bit
//   half of the LFSR or NFSR chosen by target_nfsr and upper_half).
//   Output channel (out_valid/out_stall) carries pre_output, bit j being the
//   pre-output of step t+j. Loads produce no output word.
//   Output: a step word's byte is registered in the output register, or in the skid register while out_stall holds it.
//   Throughput: one word per cycle while in_stall is low; the eight-step update is a single layer
//   of parallel XOR/AND logic on the state registers.
//   Stall: an output register plus a one-entry skid register absorb results
//   while out_stall is high; in_stall rises only once the skid entry is full
//   and falls as soon as it drains.
//   Reset (arst_n low): both shift registers clear to zero and the output
//   side empties.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grain128aead_byte_step
	import g128a_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        target_nfsr,
	input  logic        upper_half,
	input  logic [63:0] load_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pre_output
);

	state_t lin_q;
	state_t nonlin_q;
	byte_t  out_data_q;
	logic   out_valid_q;
	byte_t  skid_data_q;
	logic   skid_valid_q;

	logic   in_fire;
	logic   produce;
	logic   out_free;
	byte_t  y_byte;
	byte_t  f_byte;
	byte_t  g_byte;

	// Handshake
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid & ~skid_valid_q;
	assign produce  = in_fire & (kind == KindStep);
	assign out_free = ~out_valid_q | ~out_stall;

	// Eight-step parallel update
	always_comb begin
		y_byte = pre_byte(lin_q, nonlin_q);
		f_byte = lfsr_fb(lin_q);
		g_byte = nfsr_fb(lin_q, nonlin_q);
	end

	// Shift register state: step or load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q    <= '0;
			nonlin_q <= '0;
		end else if (produce) begin
			lin_q    <= {f_byte, lin_q[StateW-1:StepW]};
			nonlin_q <= {g_byte, nonlin_q[StateW-1:StepW]};
		end else if (in_fire) begin
			if (target_nfsr) begin
				if (upper_half) nonlin_q[StateW-1:HalfW] <= load_word;
				else            nonlin_q[HalfW-1:0]      <= load_word;
			end else begin
				if (upper_half) lin_q[StateW-1:HalfW] <= load_word;
				else            lin_q[HalfW-1:0]      <= load_word;
			end
		end
	end

	// Output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_data_q <= skid_data_q;
			else if (produce) out_data_q <= y_byte;
		end else if (produce) begin
			skid_data_q <= y_byte;
		end
	end

	assign out_valid  = out_valid_q;
	assign pre_output = out_data_q;

	// Assertions
	`ASSERT_IMPLIES(a_skid_behind_out, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(a_load_no_result, in_fire && kind == KindLoad && !out_valid_q, !out_valid_q)
	`ASSERT_NEXT(a_stall_fills_skid, produce && out_valid_q && out_stall, skid_valid_q)
	`ASSERT_NEXT(a_lfsr_load_keeps_nfsr, in_fire && kind == KindLoad && !target_nfsr,
		nonlin_q == $past(nonlin_q))

endmodule
